>>> design/crcfr_pkg.sv
package crcfr_pkg;

  // default frame geometry
  localparam int FRAME_LENGTH_DEF  = 16;
  localparam int PUMP_COUNT_DEF    = 3;
  localparam int ENCODER_COUNT_DEF = 3;

  // crc-8, msb first, no final xor
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_SEED = 8'hFF;

  // result layout: at most three encoder words and three pump load bytes
  localparam int ENCODER_SLOTS  = 3;
  localparam int MAX_LOAD_BYTES = 3;
  localparam int DECODE_BYTES   = 2 * ENCODER_SLOTS + 5 + MAX_LOAD_BYTES;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] encoder_a;
    logic [15:0] encoder_b;
    logic [15:0] encoder_c;
    logic [15:0] override_raw;
    logic [7:0]  button_bits;
    logic [7:0]  driver_error_bits;
    logic [7:0]  driver_missing_bits;
    logic [7:0]  load_first;
    logic [7:0]  load_second;
    logic [7:0]  load_third;
    logic        crc_ok;
    logic [31:0] crc_error_count;
  } out_item_t;

  // end-of-frame event from the frame tracker
  typedef struct packed {
    logic        valid;
    logic        crc_ok;
    logic [31:0] error_count;
  } frame_event_t;

  // number of frame body bytes that the decoded result ever looks at
  function automatic int stored_bytes(int frame_length, int pump_count, int encoder_count);
    int used;
    int body;
    used = 2 * encoder_count + 5 +
           ((pump_count < MAX_LOAD_BYTES) ? pump_count : MAX_LOAD_BYTES);
    body = frame_length - 1;
    return (used < body) ? used : body;
  endfunction

  // one byte through the crc, unrolled over its eight bits
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> design/crcfr_frame_track.sv
module crcfr_frame_track
  import crcfr_pkg::*;
#(
  parameter int FRAME_LENGTH  = FRAME_LENGTH_DEF,
  parameter int PUMP_COUNT    = PUMP_COUNT_DEF,
  parameter int ENCODER_COUNT = ENCODER_COUNT_DEF,
  localparam int STORE_N      = stored_bytes(FRAME_LENGTH, PUMP_COUNT, ENCODER_COUNT)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  in_item_t                  item,
  output logic [STORE_N-1:0][7:0]   committed_nxt,
  output frame_event_t              frame_event
);

  localparam int BODY_LEN = FRAME_LENGTH - 1;
  localparam int POS_W    = $clog2(FRAME_LENGTH);

  logic [POS_W-1:0]          pos_r, pos_nxt, pos_eff;
  logic [7:0]                crc_r, crc_nxt, crc_eff, crc_step;
  logic [STORE_N-1:0][7:0]   staged_r;
  logic [STORE_N-1:0][7:0]   committed_r;
  logic [31:0]               tally_r, tally_nxt;
  logic                      is_last;
  logic                      crc_match;

  // a frame start restarts the count and the crc
  always_comb begin
    pos_eff   = item.frame_start ? '0 : pos_r;
    crc_eff   = item.frame_start ? CRC_SEED : crc_r;
    is_last   = (pos_eff == POS_W'(BODY_LEN));
    crc_step  = crc8_byte(crc_eff, item.data_byte);
    crc_match = (item.data_byte == crc_eff);
  end

  // counter, crc and error tally updates
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    tally_nxt     = tally_r;
    committed_nxt = committed_r;
    if (accept) begin
      if (is_last) begin
        pos_nxt = '0;
        crc_nxt = CRC_SEED;
        if (crc_match) begin
          committed_nxt = staged_r;
        end else if (tally_r != '1) begin
          tally_nxt = tally_r + 32'd1;
        end
      end else begin
        pos_nxt = pos_eff + POS_W'(1);
        crc_nxt = crc_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= CRC_SEED;
      tally_r     <= '0;
      committed_r <= '0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      tally_r     <= tally_nxt;
      committed_r <= committed_nxt;
    end
  end

  // staging row, each entry loaded at its own byte position
  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_N; i++) begin
      if (accept && !is_last && (pos_eff == POS_W'(i))) begin
        staged_r[i] <= item.data_byte;
      end
    end
  end

  // end-of-frame event for the decoder
  always_comb begin
    frame_event.valid       = accept && is_last;
    frame_event.crc_ok      = crc_match;
    frame_event.error_count = tally_nxt;
  end

  // byte position never runs past the check byte
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(BODY_LEN))
    else $error("byte position beyond frame end");

  // error tally never goes down
  a_tally_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 tally_r >= $past(tally_r))
    else $error("error tally decreased");

  // a failed check leaves the committed copy alone
  a_hold_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_event.valid && !frame_event.crc_ok) |=> $stable(committed_r))
    else $error("committed copy changed on crc failure");

endmodule

>>> design/crcfr_decode.sv
module crcfr_decode
  import crcfr_pkg::*;
#(
  parameter int FRAME_LENGTH  = FRAME_LENGTH_DEF,
  parameter int PUMP_COUNT    = PUMP_COUNT_DEF,
  parameter int ENCODER_COUNT = ENCODER_COUNT_DEF,
  localparam int STORE_N      = stored_bytes(FRAME_LENGTH, PUMP_COUNT, ENCODER_COUNT)
) (
  input  logic [STORE_N-1:0][7:0]  committed,
  input  frame_event_t             frame_event,
  output out_item_t                result
);

  localparam int BASE = 2 * ENCODER_COUNT;

  logic [DECODE_BYTES-1:0][7:0] frame_bytes;
  logic [ENCODER_SLOTS-1:0][15:0] enc_words;
  logic [MAX_LOAD_BYTES-1:0][7:0] loads;

  // bytes beyond the stored body read as zero
  for (genvar i = 0; i < DECODE_BYTES; i++) begin : g_bytes
    if (i < STORE_N) begin : g_held
      assign frame_bytes[i] = committed[i];
    end else begin : g_zero
      assign frame_bytes[i] = '0;
    end
  end

  // encoder positions, inverted little-endian words
  for (genvar k = 0; k < ENCODER_SLOTS; k++) begin : g_enc
    if (k < ENCODER_COUNT) begin : g_on
      assign enc_words[k] = ~{frame_bytes[2*k+1], frame_bytes[2*k]};
    end else begin : g_off
      assign enc_words[k] = '0;
    end
  end

  // pump load bytes
  for (genvar p = 0; p < MAX_LOAD_BYTES; p++) begin : g_load
    if (p < PUMP_COUNT) begin : g_on
      assign loads[p] = frame_bytes[BASE+5+p];
    end else begin : g_off
      assign loads[p] = '0;
    end
  end

  // result assembly
  always_comb begin
    result.encoder_a           = enc_words[0];
    result.encoder_b           = enc_words[1];
    result.encoder_c           = enc_words[2];
    result.override_raw        = {frame_bytes[BASE+1], frame_bytes[BASE]};
    result.button_bits         = frame_bytes[BASE+2];
    result.driver_error_bits   = frame_bytes[BASE+3];
    result.driver_missing_bits = frame_bytes[BASE+4];
    result.load_first          = loads[0];
    result.load_second         = loads[1];
    result.load_third          = loads[2];
    result.crc_ok              = frame_event.crc_ok;
    result.crc_error_count     = frame_event.error_count;
  end

endmodule

>>> design/crcfr_out_buf.sv
module crcfr_out_buf
  import crcfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      out_free;

  // output register frees when empty or its transfer completes
  always_comb begin
    out_free       = !out_valid_r || out_ready;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the skid entry is only ever behind a held output
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // nothing is pushed into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into full buffer");

  // a stalled skid entry moves up as soon as the output drains
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved up");

endmodule

>>> design/crc8_status_frame_receiver.sv
// Status frame receiver: takes one link byte per transfer on the input
// channel, one byte per clock when the output side keeps up. A frame is
// FRAME_LENGTH bytes, the first FRAME_LENGTH-1 checked by CRC-8 (poly 0x07,
// seed 0xFF, msb first) against the last; frame_start drops any partial
// frame and takes its byte as byte 0. On a good check the frame body becomes
// the committed copy, on a bad one a saturating 32-bit error count goes up.
// After each check byte one result is given, decoded from the committed copy
// as that byte leaves it, and is registered in the output buffer. The crc byte
// step and the commit mux sit between the frame state and the output register.
// A two-entry output buffer holds results; in_ready only drops while both
// entries hold results that have not been taken.
module crc8_status_frame_receiver
  import crcfr_pkg::*;
#(
  parameter int FRAME_LENGTH  = FRAME_LENGTH_DEF,
  parameter int PUMP_COUNT    = PUMP_COUNT_DEF,
  parameter int ENCODER_COUNT = ENCODER_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int STORE_N = stored_bytes(FRAME_LENGTH, PUMP_COUNT, ENCODER_COUNT);

  logic                    in_xfer;
  logic [STORE_N-1:0][7:0] committed_nxt;
  frame_event_t            frame_event;
  out_item_t               result;

  assign in_xfer = in_valid && in_ready;

  // byte count, crc, staging and commit
  crcfr_frame_track #(
    .FRAME_LENGTH  (FRAME_LENGTH),
    .PUMP_COUNT    (PUMP_COUNT),
    .ENCODER_COUNT (ENCODER_COUNT)
  ) u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_xfer),
    .item          (in_data),
    .committed_nxt (committed_nxt),
    .frame_event   (frame_event)
  );

  // field decode of the committed copy
  crcfr_decode #(
    .FRAME_LENGTH  (FRAME_LENGTH),
    .PUMP_COUNT    (PUMP_COUNT),
    .ENCODER_COUNT (ENCODER_COUNT)
  ) u_decode (
    .committed   (committed_nxt),
    .frame_event (frame_event),
    .result      (result)
  );

  // output register with skid entry
  crcfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (frame_event.valid),
    .push_data (result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
